// File: hdl/threshold_weighted_centroid_top_defines.svh
// Assertion helpers shared by the centroid block.
`ifndef THRESHOLD_WEIGHTED_CENTROID_TOP_DEFINES_SVH
`define THRESHOLD_WEIGHTED_CENTROID_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TWC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twc assertion failed");

`endif

// File: hdl/twc_pkg.sv
package twc_pkg;

    localparam int BLUE_W    = 8;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int FW_W      = 11;
    localparam int MAX_WIDTH = 1024;
    localparam int FRAC_BITS = 8;
    localparam int MASS_W    = 28;
    localparam int MOM_W     = 38;
    localparam int CEN_W     = 18;
    localparam int PROD_W    = BLUE_W + COL_W;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = 5;

    localparam logic [BLUE_W-1:0] BLUE_THRESHOLD_RST = 8'd220;
    localparam logic [FW_W-1:0]   FRAME_WIDTH_RST    = 11'd896;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLUE_THRESHOLD = 1'b0,
        CFG_FRAME_WIDTH    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [BLUE_W-1:0] blue_value;
        logic              end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [CEN_W-1:0] centroid_x;
        logic [CEN_W-1:0] centroid_y;
        logic             marker_found;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [MOM_W-1:0]  moment;
        logic [MASS_W-1:0] mass;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [CEN_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: hdl/twc_div.sv
`include "threshold_weighted_centroid_top_defines.svh"

module twc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twc_pkg::t_div_req i_req,
    output twc_pkg::t_div_rsp o_rsp
);
    import twc_pkg::*;

    localparam int SHIFT = CEN_W - FRAC_BITS;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MASS_W-1:0]    r_rem;
    logic [MASS_W-1:0]    r_div;
    logic [CEN_W-1:0]     r_lo;
    logic [CEN_W-1:0]     r_quot;

    logic [MASS_W:0]      w_trial;
    logic [MASS_W:0]      w_diff;
    logic                 w_ge;
    logic                 w_ovf;

    assign w_trial = {r_rem, r_lo[CEN_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    // quotient needs more than CEN_W bits when moment >= mass << (CEN_W - FRAC_BITS)
    assign w_ovf   = i_req.moment >= {i_req.mass, {SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.mass == '0) begin
                    r_quot <= '0;
                    r_done <= 1'b1;
                end else if (w_ovf) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_rem  <= i_req.moment[MOM_W-1:SHIFT];
                    r_lo   <= {i_req.moment[SHIFT-1:0], {FRAC_BITS{1'b0}}};
                    r_div  <= i_req.mass;
                    r_cnt  <= DIV_CNT_W'(CEN_W - 1);
                    r_quot <= '0;
                end
            end else if (r_busy) begin
                // one restoring step per cycle
                r_rem  <= w_ge ? w_diff[MASS_W-1:0] : w_trial[MASS_W-1:0];
                r_quot <= {r_quot[CEN_W-2:0], w_ge};
                r_lo   <= {r_lo[CEN_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    `TWC_ASSERT_NOW(a_rem_below_div, r_busy, r_rem < r_div)
    `TWC_ASSERT_NOW(a_no_start_busy, i_req.start, !r_busy)
    `TWC_ASSERT_NOW(a_done_idle, r_done, !r_busy)

endmodule

// File: hdl/threshold_weighted_centroid_top.sv
// Pixels are taken one per cycle while not stalled; each pixel at or above the threshold
// adds to the sums when it is accepted. The end-of-frame pixel starts two divisions on one
// shared restoring divider (one quotient bit per cycle, 18 bits per axis), X then Y; a
// division ends early on zero mass or saturation. The result waits while an older result
// is stalled; the next pixel can be taken in the cycle in which the result is valid.
// Synchronous active-low reset clears counters, sums and output valid; threshold 220, width 896.
`include "threshold_weighted_centroid_top_defines.svh"

module threshold_weighted_centroid_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [twc_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  twc_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output twc_pkg::t_out_item                   o_out_data
);
    import twc_pkg::*;

    typedef enum logic [1:0] {
        S_ACC,
        S_DIV_X,
        S_DIV_Y,
        S_LOAD
    } t_state;

    t_state             r_state;
    logic [BLUE_W-1:0]  r_thr;
    logic [FW_W-1:0]    r_fw;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [MASS_W-1:0]  r_mass;
    logic [MOM_W-1:0]   r_mx;
    logic [MOM_W-1:0]   r_my;
    logic               r_div_start;
    logic [CEN_W-1:0]   r_cx;
    logic [CEN_W-1:0]   r_cy;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_in_acc;
    logic               w_eof_acc;
    logic               w_hit;
    logic [PROD_W-1:0]  w_px;
    logic [PROD_W-1:0]  w_py;
    logic [MASS_W:0]    w_mass_sum;
    logic [MOM_W:0]     w_mx_sum;
    logic [MOM_W:0]     w_my_sum;
    logic [MASS_W-1:0]  n_mass;
    logic [MOM_W-1:0]   n_mx;
    logic [MOM_W-1:0]   n_my;
    logic [FW_W-1:0]    w_col_inc;
    logic               w_wrap;
    logic               w_out_zero;
    logic               w_at_origin;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    assign o_in_stall = r_state != S_ACC;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_eof_acc  = w_in_acc && i_in_data.end_of_frame;

    assign w_hit = i_in_data.blue_value >= r_thr;
    assign w_px  = PROD_W'(i_in_data.blue_value) * PROD_W'(r_col);
    assign w_py  = PROD_W'(i_in_data.blue_value) * PROD_W'(r_row);

    // saturating accumulate
    assign w_mass_sum = {1'b0, r_mass} + (MASS_W + 1)'(i_in_data.blue_value);
    assign w_mx_sum   = {1'b0, r_mx} + (MOM_W + 1)'(w_px);
    assign w_my_sum   = {1'b0, r_my} + (MOM_W + 1)'(w_py);
    assign n_mass     = w_mass_sum[MASS_W] ? '1 : w_mass_sum[MASS_W-1:0];
    assign n_mx       = w_mx_sum[MOM_W] ? '1 : w_mx_sum[MOM_W-1:0];
    assign n_my       = w_my_sum[MOM_W] ? '1 : w_my_sum[MOM_W-1:0];

    assign w_col_inc = {1'b0, r_col} + 1'b1;
    assign w_wrap    = (w_col_inc >= r_fw) || (w_col_inc >= FW_W'(MAX_WIDTH));

    assign w_req.start  = r_div_start;
    assign w_req.moment = (r_state == S_DIV_Y) ? r_my : r_mx;
    assign w_req.mass   = r_mass;

    twc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= BLUE_THRESHOLD_RST;
            r_fw  <= FRAME_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BLUE_THRESHOLD: r_thr <= i_cfg_data[BLUE_W-1:0];
                CFG_FRAME_WIDTH:    r_fw  <= i_cfg_data[FW_W-1:0];
                default:            r_fw  <= r_fw;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_col       <= '0;
            r_row       <= '0;
            r_mass      <= '0;
            r_mx        <= '0;
            r_my        <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    if (w_in_acc) begin
                        if (w_hit) begin
                            r_mass <= n_mass;
                            r_mx   <= n_mx;
                            r_my   <= n_my;
                        end
                        if (i_in_data.end_of_frame) begin
                            r_col       <= '0;
                            r_row       <= '0;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV_X;
                        end else if (w_wrap) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= w_col_inc[COL_W-1:0];
                        end
                    end
                end
                S_DIV_X: begin
                    if (w_rsp.done) begin
                        r_cx        <= w_rsp.quot;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (w_rsp.done) begin
                        r_cy    <= w_rsp.quot;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid        <= 1'b1;
                        r_out.centroid_x   <= r_cx;
                        r_out.centroid_y   <= r_cy;
                        r_out.marker_found <= r_mass != '0;
                        r_mass             <= '0;
                        r_mx               <= '0;
                        r_my               <= '0;
                        r_state            <= S_ACC;
                    end
                end
                default: r_state <= S_ACC;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_out_zero  = (o_out_data.centroid_x == '0) && (o_out_data.centroid_y == '0);
    assign w_at_origin = (r_col == '0) && (r_row == '0);

    `TWC_ASSERT_NOW(a_done_in_div, w_rsp.done, r_state == S_DIV_X || r_state == S_DIV_Y)
    `TWC_ASSERT_NOW(a_empty_zero, o_out_valid && !o_out_data.marker_found, w_out_zero)
    `TWC_ASSERT_NEXT(a_eof_start, w_eof_acc, r_state == S_DIV_X && r_div_start && w_at_origin)

endmodule
